[hdl/merge_sort_engine_assert.svh]
// Assertion macros used by the merge sort engine top level.
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define MSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mse_pkg.sv]
// Package of the merge sort engine: sizes, request codes, command and status types.
`timescale 1ns / 1ps

package mse_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 1024;

  // Request codes carried in req_type
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic acc_load;    // load transaction accepted: store or drop the value
    logic acc_read;    // read transaction accepted: latch flags, fetch value
    logic sort_init;   // start a sort: run width 1, source buffer A
    logic pass_init;   // start a merge pass at the first run
    logic pass_end;    // swap buffers, double the run width
    logic run_init;    // set up bounds and cursors of one pair of runs
    logic run_end;     // advance to the next pair of runs
    logic fetch;       // read both run heads from the source buffer
    logic merge;       // write the smaller head, advance cursors
    logic set_sorted;  // sort finished, open the batch for reads
    logic out_load;    // move the pending read result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic width_ge_n;  // run width covers the whole batch
    logic lo_ge_n;     // no run pair left in this pass
    logic k_eq_hi;     // current run pair fully merged
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

[hdl/mse_channels.sv]
// Stream interfaces of the merge sort engine: request channel and result channel.
`timescale 1ns / 1ps

interface mse_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [mse_pkg::DATA_W-1:0]   load_value;
  logic                                load_last;

  modport source (output valid, output req_type, output load_value, output load_last,
                  input ready);
  modport sink   (input valid, input req_type, input load_value, input load_last,
                  output ready);
endinterface

interface mse_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mse_pkg::DATA_W-1:0]   sorted_value;
  logic                                sorted_last;
  logic                                empty_flag;
  logic                                overflow_flag;

  modport source (output valid, output sorted_value, output sorted_last,
                  output empty_flag, output overflow_flag, input ready);
  modport sink   (input valid, input sorted_value, input sorted_last,
                  input empty_flag, input overflow_flag, output ready);
endinterface

[hdl/mse_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps

module mse_ram #(
  parameter int WIDTH = mse_pkg::DATA_W,
  parameter int DEPTH = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re0,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic                     re1,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports: data holds while the enable is low
  always_ff @(posedge clk) begin
    if (re0) begin
      rdata0 <= mem[raddr0];
    end
    if (re1) begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule

[hdl/mse_ctrl.sv]
// Controller of the merge sort engine: request handshake and merge pass sequencing.
`timescale 1ns / 1ps

module mse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          req_type,
  input  logic          load_last,
  input  mse_pkg::sts_t sts,
  output logic          in_ready,
  output mse_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PASS  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_MERGE = 3'd4;
  localparam logic [2:0] S_RDATA = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == mse_pkg::REQ_READ) begin
            cmd.acc_read = 1'b1;
            state_nxt    = S_RDATA;
          end else begin
            cmd.acc_load = 1'b1;
            if (load_last) begin
              cmd.sort_init = 1'b1;
              state_nxt     = S_PASS;
            end
          end
        end
      end
      S_PASS: begin
        if (sts.width_ge_n) begin
          cmd.set_sorted = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.pass_init = 1'b1;
          state_nxt     = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.lo_ge_n) begin
          cmd.pass_end = 1'b1;
          state_nxt    = S_PASS;
        end else begin
          cmd.run_init = 1'b1;
          state_nxt    = S_FETCH;
        end
      end
      S_FETCH: begin
        if (sts.k_eq_hi) begin
          cmd.run_end = 1'b1;
          state_nxt   = S_RUN;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = S_FETCH;
      end
      S_RDATA: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/mse_dpath.sv]
// Datapath of the merge sort engine: ping-pong buffers, cursors, compare and output register.
`timescale 1ns / 1ps

module mse_dpath #(
  parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mse_pkg::cmd_t                     cmd,
  output mse_pkg::sts_t                     sts,
  input  logic signed [mse_pkg::DATA_W-1:0] load_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [mse_pkg::DATA_W-1:0] sorted_value,
  output logic                              sorted_last,
  output logic                              empty_flag,
  output logic                              overflow_flag
);

  localparam int AW = $clog2(MAX_ITEMS);      // buffer address
  localparam int CW = $clog2(MAX_ITEMS + 1);  // counts up to MAX_ITEMS
  localparam int WW = CW + 1;                 // run width and bound sums
  localparam int DW = mse_pkg::DATA_W;

  // Batch state
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rptr_r, rptr_nxt;
  logic          dropped_r, dropped_nxt;
  logic          sorted_r, sorted_nxt;
  logic          src_sel_r, src_sel_nxt;  // 0: buffer A holds the source data

  // Merge cursors
  logic [WW-1:0] width_r, width_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;

  // Pending read result and output register
  logic          pend_empty_r, pend_last_r, pend_ovf_r;
  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  logic          out_last_r, out_empty_r, out_ovf_r;

  // Buffer ports
  logic          a_we, b_we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic          a_re0, a_re1, b_re0, b_re1;
  logic [AW-1:0] raddr0, raddr1;
  logic [DW-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic [DW-1:0] src_rd0, src_rd1;

  // Helpers
  logic [CW-1:0] load_base;
  logic          load_fits;
  logic          read_hit;
  logic [WW-1:0] n_ext;
  logic [WW-1:0] mid_sum, mid_full, hi_sum, hi_full;
  logic          take_left;
  logic [DW-1:0] merge_value;

  // Load slot: a load after a sorted batch starts a new one
  assign load_base = sorted_r ? '0 : count_r;
  assign load_fits = load_base < CW'(MAX_ITEMS);
  assign read_hit  = sorted_r && (rptr_r < count_r);

  // Run bounds: mid = min(lo + width, n), hi = min(mid + width, n)
  assign n_ext    = {1'b0, count_r};
  assign mid_sum  = {1'b0, lo_r} + width_r;
  assign mid_full = (mid_sum < n_ext) ? mid_sum : n_ext;
  assign hi_sum   = mid_full + width_r;
  assign hi_full  = (hi_sum < n_ext) ? hi_sum : n_ext;

  // Pick the left head on a tie to keep the sort stable
  assign src_rd0     = src_sel_r ? b_rd0 : a_rd0;
  assign src_rd1     = src_sel_r ? b_rd1 : a_rd1;
  assign take_left   = (i_r < mid_r) &&
                       ((j_r >= hi_r) || ($signed(src_rd0) <= $signed(src_rd1)));
  assign merge_value = take_left ? src_rd0 : src_rd1;

  // Status to the controller
  assign sts.width_ge_n = width_r >= n_ext;
  assign sts.lo_ge_n    = lo_r >= count_r;
  assign sts.k_eq_hi    = k_r == hi_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // Buffer port steering: loads fill A, merges write the destination buffer
  assign waddr  = cmd.acc_load ? load_base[AW-1:0] : k_r[AW-1:0];
  assign wdata  = cmd.acc_load ? DW'(load_value) : merge_value;
  assign a_we   = (cmd.acc_load && load_fits) || (cmd.merge && src_sel_r);
  assign b_we   = cmd.merge && !src_sel_r;
  assign raddr0 = cmd.acc_read ? rptr_r[AW-1:0] : i_r[AW-1:0];
  assign raddr1 = j_r[AW-1:0];
  assign a_re0  = (cmd.acc_read || cmd.fetch) && !src_sel_r;
  assign b_re0  = (cmd.acc_read || cmd.fetch) && src_sel_r;
  assign a_re1  = cmd.fetch && !src_sel_r;
  assign b_re1  = cmd.fetch && src_sel_r;

  mse_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ITEMS)
  ) u_buf_a (
    .clk    (clk),
    .we     (a_we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re0    (a_re0),
    .raddr0 (raddr0),
    .rdata0 (a_rd0),
    .re1    (a_re1),
    .raddr1 (raddr1),
    .rdata1 (a_rd1)
  );

  mse_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ITEMS)
  ) u_buf_b (
    .clk    (clk),
    .we     (b_we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re0    (b_re0),
    .raddr0 (raddr0),
    .rdata0 (b_rd0),
    .re1    (b_re1),
    .raddr1 (raddr1),
    .rdata1 (b_rd1)
  );

  // Batch bookkeeping
  always_comb begin
    count_nxt   = count_r;
    rptr_nxt    = rptr_r;
    dropped_nxt = dropped_r;
    sorted_nxt  = sorted_r;
    src_sel_nxt = src_sel_r;
    if (cmd.acc_load) begin
      if (sorted_r) begin
        sorted_nxt  = 1'b0;
        rptr_nxt    = '0;
        dropped_nxt = 1'b0;
      end
      if (load_fits) begin
        count_nxt = load_base + CW'(1);
      end else begin
        count_nxt   = load_base;
        dropped_nxt = 1'b1;
      end
    end
    if (cmd.sort_init) begin
      src_sel_nxt = 1'b0;
      rptr_nxt    = '0;
    end
    if (cmd.pass_end) begin
      src_sel_nxt = !src_sel_r;
    end
    if (cmd.set_sorted) begin
      sorted_nxt = 1'b1;
    end
    if (cmd.acc_read && read_hit) begin
      rptr_nxt = rptr_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rptr_r    <= '0;
      dropped_r <= 1'b0;
      sorted_r  <= 1'b0;
      src_sel_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      rptr_r    <= rptr_nxt;
      dropped_r <= dropped_nxt;
      sorted_r  <= sorted_nxt;
      src_sel_r <= src_sel_nxt;
    end
  end

  // Merge cursors
  always_comb begin
    width_nxt = width_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    if (cmd.sort_init) begin
      width_nxt = WW'(1);
    end
    if (cmd.pass_init) begin
      lo_nxt = '0;
    end
    if (cmd.pass_end) begin
      width_nxt = width_r << 1;
    end
    if (cmd.run_init) begin
      mid_nxt = mid_full[CW-1:0];
      hi_nxt  = hi_full[CW-1:0];
      i_nxt   = lo_r;
      j_nxt   = mid_full[CW-1:0];
      k_nxt   = lo_r;
    end
    // the last pair always ends at the batch end, so the next pair starts at hi
    if (cmd.run_end) begin
      lo_nxt = hi_r;
    end
    if (cmd.merge) begin
      k_nxt = k_r + CW'(1);
      if (take_left) begin
        i_nxt = i_r + CW'(1);
      end else begin
        j_nxt = j_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    width_r <= width_nxt;
    lo_r    <= lo_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
  end

  // Latch the flags of an accepted read
  always_ff @(posedge clk) begin
    if (cmd.acc_read) begin
      pend_empty_r <= !read_hit;
      pend_last_r  <= read_hit && ((rptr_r + CW'(1)) == count_r);
      pend_ovf_r   <= dropped_r;
    end
  end

  // Output register: hold until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= pend_empty_r ? '0 : src_rd0;
      out_last_r  <= pend_last_r;
      out_empty_r <= pend_empty_r;
      out_ovf_r   <= pend_ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign sorted_value  = $signed(out_value_r);
  assign sorted_last   = out_last_r;
  assign empty_flag    = out_empty_r;
  assign overflow_flag = out_ovf_r;

endmodule

[hdl/merge_sort_engine.sv]
// Top level of the merge sort engine: controller, datapath and channel hookup.
//
//   channel     dir  payload                                             handshake
//   in_stream   in   req_type, load_value, load_last                     valid/ready
//   out_stream  out  sorted_value, sorted_last, empty_flag, overflow_flag valid/ready
//
// A load transaction needs no wait state; one request is accepted per cycle while idle.
// A read transaction passes the buffer read register, then enters the output register once free.
// The last load starts the sort: ceil(log2 N) passes, each merging run pairs element by element
// (fetch, then merge); in_ready stays low.
// Reset is synchronous, active low; buffer contents are not cleared and need no sweep.
// The output register holds a result under out_ready low; requests are taken meanwhile.
`timescale 1ns / 1ps

`include "merge_sort_engine_assert.svh"

module merge_sort_engine #(
  parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mse_in_if.sink     in_stream,
  mse_out_if.source  out_stream
);

  mse_pkg::cmd_t cmd;
  mse_pkg::sts_t sts;
  logic          read_fire;

  mse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .req_type  (in_stream.req_type),
    .load_last (in_stream.load_last),
    .sts       (sts),
    .in_ready  (in_stream.ready),
    .cmd       (cmd)
  );

  mse_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .load_value    (in_stream.load_value),
    .out_ready     (out_stream.ready),
    .out_valid     (out_stream.valid),
    .sorted_value  (out_stream.sorted_value),
    .sorted_last   (out_stream.sorted_last),
    .empty_flag    (out_stream.empty_flag),
    .overflow_flag (out_stream.overflow_flag)
  );

  // Read transaction accepted on the request channel
  assign read_fire = in_stream.valid && in_stream.ready &&
                     (in_stream.req_type == mse_pkg::REQ_READ);

  // No request is taken while a merge step runs
  `MSE_ASSERT_SAME(a_no_accept_in_merge, cmd.merge, !in_stream.ready, "request taken during merge")
  // A result only enters a free output register
  `MSE_ASSERT_SAME(a_out_load_free, cmd.out_load, sts.out_free, "output register overwritten")
  // An accepted read blocks the request channel for the next cycle
  `MSE_ASSERT_NEXT(a_read_blocks, read_fire, !in_stream.ready, "read not waited for")
  // The closing load enters the sort
  `MSE_ASSERT_NEXT(a_last_sorts, cmd.acc_load && cmd.sort_init, !in_stream.ready, "sort did not start")

endmodule
